FILE: design/calendar_gps_time_convert_top_macros.svh
// Assertion macros shared by the calendar and GPS time converter modules.
`ifndef CALENDAR_GPS_TIME_CONVERT_TOP_MACROS_SVH
`define CALENDAR_GPS_TIME_CONVERT_TOP_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define CGTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define CGTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cgtc_pkg.sv
// Types, constants and tables of the calendar and GPS time converter.
package cgtc_pkg;

  localparam int NUM_STAGES = 5;
  localparam int DP_STAGES  = NUM_STAGES - 1;

  localparam logic [11:0] YEAR_MIN      = 12'd1980;
  localparam logic [11:0] YEAR_MAX      = 12'd2210;
  localparam logic [11:0] YEAR_BASE     = 12'd1980;
  localparam logic [3:0]  MONTH_MAX     = 4'd12;
  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [5:0]  MIN_MAX       = 6'd59;
  localparam logic [13:0] WEEK_MAX      = 14'd12000;
  localparam logic [19:0] SOW_MAX       = 20'd604799;
  localparam logic [16:0] GPS_EPOCH_MJD = 17'd44244;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [20:0] EPOCH_JDAY    = 21'd723263;
  localparam logic [16:0] DAY_BASE      = 17'd43810;
  localparam logic [18:0] CYC_BASE      = 19'd175732;

  localparam logic [17:0] RECIP_7    = 18'd149797;
  localparam int          SHIFT_7    = 20;
  localparam logic [18:0] RECIP_1461 = 19'd367469;
  localparam int          SHIFT_1461 = 29;
  localparam logic [12:0] RECIP_225  = 13'd4661;
  localparam int          SHIFT_225  = 20;
  localparam logic [10:0] RECIP_15   = 11'd1093;
  localparam int          SHIFT_15   = 14;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    logic [13:0] week;
    logic [19:0] week_seconds;
  } gps_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [13:0] out_week;
    logic [19:0] out_week_seconds;
    logic [16:0] mjd_day;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // Whole days in n months of 30.6001 days each.
  function automatic logic [8:0] month_offset(input logic [3:0] n);
    logic [8:0] val;
    case (n)
      4'd1:    val = 9'd30;
      4'd2:    val = 9'd61;
      4'd3:    val = 9'd91;
      4'd4:    val = 9'd122;
      4'd5:    val = 9'd153;
      4'd6:    val = 9'd183;
      4'd7:    val = 9'd214;
      4'd8:    val = 9'd244;
      4'd9:    val = 9'd275;
      4'd10:   val = 9'd306;
      4'd11:   val = 9'd336;
      4'd12:   val = 9'd367;
      4'd13:   val = 9'd397;
      4'd14:   val = 9'd428;
      4'd15:   val = 9'd459;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: design/cgtc_if.sv
// Valid/ready channel interfaces for the converter's input and result items.
interface cgtc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [13:0] gps_week;
  logic [19:0] week_seconds;

  modport source (
    output valid, mode, year, month, day, hour, minute, second, gps_week, week_seconds,
    input  ready
  );
  modport sink (
    input  valid, mode, year, month, day, hour, minute, second, gps_week, week_seconds,
    output ready
  );
endinterface

interface cgtc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [13:0] out_week;
  logic [19:0] out_week_seconds;
  logic [16:0] mjd_day;
  logic        out_of_range;

  modport source (
    output valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           out_week, out_week_seconds, mjd_day, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           out_week, out_week_seconds, mjd_day, out_of_range,
    output ready
  );
endinterface

FILE: design/cgtc_pipe_ctrl.sv
// Stage valid bits and load enables of the converter pipeline.
`include "calendar_gps_time_convert_top_macros.svh"

module cgtc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output cgtc_pkg::pipe_ctl_t ctl
);
  import cgtc_pkg::*;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] vin;
  logic [NUM_STAGES:0]   rdy;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    vin = {valid_r[NUM_STAGES-2:0], in_valid};
    for (int i = 0; i < NUM_STAGES; i++) begin
      valid_nxt[i] = rdy[i] ? vin[i] : valid_r[i];
    end
    ctl.load  = rdy[NUM_STAGES-1:0] & vin;
    ctl.valid = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  `CGTC_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `CGTC_ASSERT_NOW(a_empty_tail_ready, !valid_r[NUM_STAGES-1], in_ready, "input blocked with empty output stage")

endmodule

FILE: design/cgtc_fwd.sv
// Calendar date and time to GPS week, seconds of week and MJD, four stages.
`include "calendar_gps_time_convert_top_macros.svh"

module cgtc_fwd (
  input  logic                clk,
  input  logic                rst_n,
  input  cgtc_pkg::pipe_ctl_t ctl,
  input  cgtc_pkg::cal_t      cal_in,
  output cgtc_pkg::out_item_t res
);
  import cgtc_pkg::*;

  localparam int PW = 17 + 18;

  logic        bad1_nxt;
  logic        early;
  logic [11:0] ya;
  logic [3:0]  ma;
  logic [3:0]  mn1;
  logic [20:0] jday1_nxt;
  logic [16:0] tod1_nxt;

  cal_t        cal1_r;
  logic        bad1_r;
  logic [20:0] jday1_r;
  logic [16:0] tod1_r;

  logic          before_epoch;
  logic [16:0]   days2_nxt;
  logic [PW-1:0] prodw2_nxt;

  cal_t          cal2_r;
  logic          bad2_r;
  logic [16:0]   days2_r;
  logic [16:0]   tod2_r;
  logic [PW-1:0] prodw2_r;

  logic [14:0] week_full;
  logic [16:0] rem_full;
  logic        week_over;

  cal_t        cal3_r;
  logic        bad3_r;
  logic [13:0] week3_r;
  logic [2:0]  rem3_r;
  logic [16:0] days3_r;
  logic [16:0] tod3_r;

  logic [19:0] wsec4_nxt;
  logic [16:0] mjd4_nxt;

  cal_t        cal4_r;
  logic        bad4_r;
  logic [13:0] week4_r;
  logic [19:0] wsec4_r;
  logic [16:0] mjd4_r;

  always_comb begin
    bad1_nxt = (cal_in.year < YEAR_MIN) || (cal_in.year > YEAR_MAX) ||
               (cal_in.month == 4'd0) || (cal_in.month > MONTH_MAX) ||
               (cal_in.day == 5'd0) || (cal_in.hour > HOUR_MAX) ||
               (cal_in.minute > MIN_MAX) || (cal_in.second > MIN_MAX);
    early     = cal_in.month <= 4'd2;
    ya        = early ? cal_in.year - 12'd1 : cal_in.year;
    ma        = early ? cal_in.month + 4'd12 : cal_in.month;
    mn1       = ma + 4'd1;
    jday1_nxt = 21'(ya) * 21'd365 + 21'(ya[11:2]) + 21'(month_offset(mn1)) +
                21'(cal_in.day);
    tod1_nxt  = 17'(cal_in.hour) * 17'd3600 + 17'(cal_in.minute) * 17'd60 +
                17'(cal_in.second);
  end

  always_comb begin
    before_epoch = jday1_r < EPOCH_JDAY;
    days2_nxt    = 17'(jday1_r - EPOCH_JDAY);
    prodw2_nxt   = PW'(days2_nxt) * PW'(RECIP_7);
  end

  always_comb begin
    week_full = prodw2_r[PW-1:SHIFT_7];
    rem_full  = days2_r - 17'(week_full) * 17'd7;
    week_over = week_full > 15'(WEEK_MAX);
  end

  always_comb begin
    wsec4_nxt = 20'(rem3_r) * 20'(SEC_PER_DAY) + 20'(tod3_r);
    mjd4_nxt  = days3_r + GPS_EPOCH_MJD;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      cal1_r  <= cal_in;
      bad1_r  <= bad1_nxt;
      jday1_r <= jday1_nxt;
      tod1_r  <= tod1_nxt;
    end
    if (ctl.load[1]) begin
      cal2_r   <= cal1_r;
      bad2_r   <= bad1_r || before_epoch;
      days2_r  <= days2_nxt;
      tod2_r   <= tod1_r;
      prodw2_r <= prodw2_nxt;
    end
    if (ctl.load[2]) begin
      cal3_r  <= cal2_r;
      bad3_r  <= bad2_r || week_over;
      week3_r <= week_full[13:0];
      rem3_r  <= rem_full[2:0];
      days3_r <= days2_r;
      tod3_r  <= tod2_r;
    end
    if (ctl.load[3]) begin
      cal4_r  <= cal3_r;
      bad4_r  <= bad3_r;
      week4_r <= week3_r;
      wsec4_r <= wsec4_nxt;
      mjd4_r  <= mjd4_nxt;
    end
  end

  always_comb begin
    res.out_year         = cal4_r.year;
    res.out_month        = cal4_r.month;
    res.out_day          = cal4_r.day;
    res.out_hour         = cal4_r.hour;
    res.out_minute       = cal4_r.minute;
    res.out_second       = cal4_r.second;
    res.out_week         = bad4_r ? '0 : week4_r;
    res.out_week_seconds = bad4_r ? '0 : wsec4_r;
    res.mjd_day          = bad4_r ? '0 : mjd4_r;
    res.out_of_range     = bad4_r;
  end

  `CGTC_ASSERT_NOW(a_fwd_rem, ctl.valid[2], rem3_r <= 3'd6, "day of week remainder above six")
  `CGTC_ASSERT_NOW(a_fwd_wsec, ctl.valid[3] && !bad4_r, wsec4_r <= SOW_MAX, "seconds of week too large")

endmodule

FILE: design/cgtc_rev.sv
// GPS week and seconds of week to calendar date, time of day and MJD, four stages.
`include "calendar_gps_time_convert_top_macros.svh"

module cgtc_rev (
  input  logic                clk,
  input  logic                rst_n,
  input  cgtc_pkg::pipe_ctl_t ctl,
  input  cgtc_pkg::gps_t      gps_in,
  output cgtc_pkg::out_item_t res
);
  import cgtc_pkg::*;

  localparam int PCW = 19 + 19;
  localparam int PHW = 13 + 13;
  localparam int PMW = 20;

  logic        bad1_nxt;
  logic [2:0]  dix;
  logic [19:0] sod_full;
  logic [16:0] mjd1_nxt;

  gps_t        gps1_r;
  logic        bad1_r;
  logic [16:0] mjd1_r;
  logic [16:0] sod1_r;

  logic [18:0]    cyc;
  logic [PCW-1:0] prodc2_nxt;
  logic [PHW-1:0] prodh2_nxt;

  gps_t           gps2_r;
  logic           bad2_r;
  logic [16:0]    mjd2_r;
  logic [16:0]    sod2_r;
  logic [PCW-1:0] prodc2_r;
  logic [PHW-1:0] prodh2_r;

  logic [7:0]  q3_nxt;
  logic [4:0]  hour3_nxt;
  logic [16:0] fday;
  logic [16:0] remh_full;

  gps_t        gps3_r;
  logic        bad3_r;
  logic [16:0] mjd3_r;
  logic [7:0]  q3_r;
  logic [8:0]  f3_r;
  logic [4:0]  hour3_r;
  logic [11:0] remh3_r;

  logic [3:0]     e4_nxt;
  logic [PMW-1:0] prodm4_nxt;

  gps_t           gps4_r;
  logic           bad4_r;
  logic [16:0]    mjd4_r;
  logic [7:0]     q4_r;
  logic [8:0]     f4_r;
  logic [3:0]     e4_r;
  logic [4:0]     hour4_r;
  logic [11:0]    remh4_r;
  logic [PMW-1:0] prodm4_r;

  logic [5:0]  minute;
  logic [11:0] sec_full;
  logic [8:0]  day_full;
  logic [3:0]  mon;
  logic [11:0] yr;

  always_comb begin
    bad1_nxt = (gps_in.week > WEEK_MAX) || (gps_in.week_seconds > SOW_MAX);
    dix = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (gps_in.week_seconds >= 20'(k) * 20'(SEC_PER_DAY)) begin
        dix = 3'(k);
      end
    end
    sod_full = gps_in.week_seconds - 20'(dix) * 20'(SEC_PER_DAY);
    mjd1_nxt = GPS_EPOCH_MJD + 17'(gps_in.week) * 17'd7 + 17'(dix);
  end

  // The year count above the base CYC_BASE comes from a reciprocal of 1461, the hour from one of 225.
  always_comb begin
    cyc        = {mjd1_r, 2'b00} - CYC_BASE;
    prodc2_nxt = PCW'(cyc) * PCW'(RECIP_1461);
    prodh2_nxt = PHW'(sod1_r[16:4]) * PHW'(RECIP_225);
  end

  always_comb begin
    q3_nxt    = prodc2_r[SHIFT_1461+7:SHIFT_1461];
    hour3_nxt = prodh2_r[SHIFT_225+4:SHIFT_225];
    fday      = mjd2_r - DAY_BASE - 17'(q3_nxt) * 17'd365 -
                17'((9'(q3_nxt) + 9'd3) >> 2);
    remh_full = sod2_r - 17'(hour3_nxt) * 17'd3600;
  end

  always_comb begin
    e4_nxt = 4'd0;
    for (int k = 1; k <= 15; k++) begin
      if (f3_r > month_offset(4'(k))) begin
        e4_nxt = 4'(k);
      end
    end
    prodm4_nxt = PMW'(remh3_r[11:2]) * PMW'(RECIP_15);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      gps1_r <= gps_in;
      bad1_r <= bad1_nxt;
      mjd1_r <= mjd1_nxt;
      sod1_r <= sod_full[16:0];
    end
    if (ctl.load[1]) begin
      gps2_r   <= gps1_r;
      bad2_r   <= bad1_r;
      mjd2_r   <= mjd1_r;
      sod2_r   <= sod1_r;
      prodc2_r <= prodc2_nxt;
      prodh2_r <= prodh2_nxt;
    end
    if (ctl.load[2]) begin
      gps3_r  <= gps2_r;
      bad3_r  <= bad2_r;
      mjd3_r  <= mjd2_r;
      q3_r    <= q3_nxt;
      f3_r    <= fday[8:0];
      hour3_r <= hour3_nxt;
      remh3_r <= remh_full[11:0];
    end
    if (ctl.load[3]) begin
      gps4_r   <= gps3_r;
      bad4_r   <= bad3_r;
      mjd4_r   <= mjd3_r;
      q4_r     <= q3_r;
      f4_r     <= f3_r;
      e4_r     <= e4_nxt;
      hour4_r  <= hour3_r;
      remh4_r  <= remh3_r;
      prodm4_r <= prodm4_nxt;
    end
  end

  always_comb begin
    minute   = prodm4_r[SHIFT_15+5:SHIFT_15];
    sec_full = remh4_r - 12'(minute) * 12'd60;
    day_full = f4_r - month_offset(e4_r);
    mon      = (e4_r < 4'd14) ? e4_r - 4'd1 : e4_r - 4'd13;
    yr       = YEAR_BASE + 12'(q4_r) - {11'd0, mon >= 4'd3};

    res.out_year         = bad4_r ? '0 : yr;
    res.out_month        = bad4_r ? '0 : mon;
    res.out_day          = bad4_r ? '0 : day_full[4:0];
    res.out_hour         = bad4_r ? '0 : hour4_r;
    res.out_minute       = bad4_r ? '0 : minute;
    res.out_second       = bad4_r ? '0 : sec_full[5:0];
    res.out_week         = gps4_r.week;
    res.out_week_seconds = gps4_r.week_seconds;
    res.mjd_day          = bad4_r ? '0 : mjd4_r;
    res.out_of_range     = bad4_r;
  end

  `CGTC_ASSERT_NOW(a_rev_tod, ctl.valid[2] && !bad3_r, (hour3_r <= HOUR_MAX) && (remh3_r < 12'd3600), "time of day split out of range")
  `CGTC_ASSERT_NOW(a_rev_month, ctl.valid[3] && !bad4_r, (f4_r <= 9'd488) && (e4_r >= 4'd4), "day of year count outside the month table")

endmodule

FILE: design/calendar_gps_time_convert_top.sv
// Top level of the calendar and GPS time converter.
//
// Channel  Direction  Handshake    Payload
// in_ch    input      valid/ready  mode, calendar date and time, GPS week and seconds
// out_ch   output     valid/ready  date and time, GPS week and seconds, MJD, range flag
//
// One item enters per cycle while out_ch is not stalled; a result passes through five register
// stages (four arithmetic stages and the output register) before it is valid.
// Reset clears only the stage valid bits.
// A stalled result holds in the output register; each stage holds while the one after it
// is full and blocked, and empty stages keep filling, so in_ch.ready falls only when all
// five stages hold items.
module calendar_gps_time_convert_top (
  input logic       clk,
  input logic       rst_n,
  cgtc_in_if.sink   in_ch,
  cgtc_out_if.source out_ch
);
  import cgtc_pkg::*;

  pipe_ctl_t            ctl;
  cal_t                 in_cal;
  gps_t                 in_gps;
  out_item_t            fwd_res;
  out_item_t            rev_res;
  out_item_t            res_nxt;
  out_item_t            res_r;
  logic [DP_STAGES-1:0] mode_r;

  always_comb begin
    in_cal.year         = in_ch.year;
    in_cal.month        = in_ch.month;
    in_cal.day          = in_ch.day;
    in_cal.hour         = in_ch.hour;
    in_cal.minute       = in_ch.minute;
    in_cal.second       = in_ch.second;
    in_gps.week         = in_ch.gps_week;
    in_gps.week_seconds = in_ch.week_seconds;
  end

  cgtc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .ctl       (ctl)
  );

  cgtc_fwd u_fwd (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cal_in (in_cal),
    .res    (fwd_res)
  );

  cgtc_rev u_rev (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .gps_in (in_gps),
    .res    (rev_res)
  );

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      mode_r[0] <= in_ch.mode;
    end
    for (int i = 1; i < DP_STAGES; i++) begin
      if (ctl.load[i]) begin
        mode_r[i] <= mode_r[i-1];
      end
    end
  end

  assign res_nxt = mode_r[DP_STAGES-1] ? rev_res : fwd_res;

  always_ff @(posedge clk) begin
    if (ctl.load[NUM_STAGES-1]) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    out_ch.out_year         = res_r.out_year;
    out_ch.out_month        = res_r.out_month;
    out_ch.out_day          = res_r.out_day;
    out_ch.out_hour         = res_r.out_hour;
    out_ch.out_minute       = res_r.out_minute;
    out_ch.out_second       = res_r.out_second;
    out_ch.out_week         = res_r.out_week;
    out_ch.out_week_seconds = res_r.out_week_seconds;
    out_ch.mjd_day          = res_r.mjd_day;
    out_ch.out_of_range     = res_r.out_of_range;
  end

endmodule
